@@ hdl/dq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg: shared types and codes of the double-ended queue
// Command and status codes, the request and result beat layouts, the
// classified command that passes from the front part to the back part, and
// the back part's state encoding.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_LIST_FWD   = 3'd4;
    localparam logic [2:0] CMD_LIST_BWD   = 3'd5;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_REMOVED  = 3'd1;
    localparam logic [2:0] ST_LISTED   = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_LIST_FWD,
        OP_LIST_BWD
    } op_t;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] value;
    } request_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] item;
        logic               last;
    } result_t;

    typedef struct packed {
        op_t                op;
        logic signed [31:0] value;
    } cmd_beat_t;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } back_state_t;

endpackage : dq_pkg
`default_nettype wire

@@ hdl/double_ended_queue_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_core: bounded double-ended queue of signed 32-bit values
// Requests enter through a queue-style port: a beat is taken at a clock edge
// with push high and full low. Results leave the same way: the oldest result
// sits on the result port while empty is low and goes at an edge with pop
// high. Push front/back, pop front/back and list forward/backward are
// supported; unused command codes are taken and dropped without a result.
// A push, a full or an empty result passes the command queue and then the
// result queue; a pop result also passes the registered read port of the
// ring memory. A listing's first element takes the path of a pop result; the
// rest follow one element per cycle while the result queue has space, paced
// by the single read port of the ring. A push, a full or an empty result is
// handled in the back part's idle state; a pop reads the ring, then emits.
// A two-entry command queue and a two-entry result queue separate the
// sides; while pop stays low the back part stops once the result queue is
// full, and full rises once the command queue fills behind it.
// Reset empties the ring (front index and occupancy to zero) and both queues
// at once; no clearing pass is needed, entries are read only after written.
// ----------------------------------------------------------------------------
module double_ended_queue_core #(
    parameter int CAPACITY = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire dq_pkg::request_t  request,
    output logic                   empty,
    input  wire logic              pop,
    output dq_pkg::result_t        result
);
    import dq_pkg::*;

    logic      cmd_valid;
    logic      cmd_take;
    cmd_beat_t cmd;

    dq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    dq_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule : double_ended_queue_core
`default_nettype wire

@@ hdl/dq_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dq_front: request intake and command queue
// Accepts request beats, decodes the command code and holds the decoded
// commands in a two-entry queue for the back part. Unused codes are dropped.
// ----------------------------------------------------------------------------
module dq_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire dq_pkg::request_t  request,
    output logic                   cmd_valid,
    output dq_pkg::cmd_beat_t      cmd,
    input  wire logic              cmd_take
);
    import dq_pkg::*;

    cmd_beat_t  q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       code_ok;
    op_t        op;
    logic       accept;
    logic       store;
    logic       take;

    always_comb
    begin
        code_ok = 1'b1;
        op      = OP_PUSH_FRONT;
        unique case (request.cmd)
            CMD_PUSH_FRONT: op = OP_PUSH_FRONT;
            CMD_PUSH_BACK:  op = OP_PUSH_BACK;
            CMD_POP_FRONT:  op = OP_POP_FRONT;
            CMD_POP_BACK:   op = OP_POP_BACK;
            CMD_LIST_FWD:   op = OP_LIST_FWD;
            CMD_LIST_BWD:   op = OP_LIST_BWD;
            default:        code_ok = 1'b0;
        endcase
    end

    assign full      = (count_reg == 2'd2);
    assign accept    = push && !full;
    assign store     = accept && code_ok;
    assign cmd_valid = (count_reg != 2'd0);
    assign take      = cmd_take && cmd_valid;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = store ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, store} - {1'b0, take};
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            q_reg[wr_ptr_reg] <= '{op: op, value: request.value};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("command queue count out of range");

    a_no_take_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0) |-> !take)
        else $error("command taken from an empty queue");

    a_drop_unused: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !code_ok && !take) |=> $stable(count_reg))
        else $error("unused command code was queued");
`endif

endmodule : dq_front
`default_nettype wire

@@ hdl/dq_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dq_back: ring buffer execution and result queue
// Holds the ring memory with its front index and occupancy, carries out each
// decoded command, walks the ring for listings and places result beats in a
// two-entry result queue.
// ----------------------------------------------------------------------------
module dq_back #(
    parameter int CAPACITY = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    input  wire dq_pkg::cmd_beat_t  cmd,
    output logic                    cmd_take,
    output logic                    empty,
    input  wire logic               pop,
    output dq_pkg::result_t         result
);
    import dq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
        return (a == AW'(CAPACITY - 1)) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] a);
        return (a == '0) ? AW'(CAPACITY - 1) : a - 1'b1;
    endfunction

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW + 1)'(CAPACITY))
        begin
            s = s - (AW + 1)'(CAPACITY);
        end
        return s[AW-1:0];
    endfunction

    logic [31:0]  mem [CAPACITY];
    logic [31:0]  rdata_reg;
    logic         mem_we;
    logic [AW-1:0] waddr;
    logic         mem_re;
    logic [AW-1:0] raddr;

    back_state_t  state_reg;
    back_state_t  state_next;
    logic [AW-1:0] front_reg;
    logic [AW-1:0] front_next;
    logic [CW-1:0] occ_reg;
    logic [CW-1:0] occ_next;
    logic [AW-1:0] ptr_reg;
    logic [AW-1:0] ptr_next;
    logic [CW-1:0] rem_reg;
    logic [CW-1:0] rem_next;
    logic         bwd_reg;
    logic         bwd_next;
    logic [2:0]   emit_status_reg;
    logic [2:0]   emit_status_next;

    logic [CW-1:0] occ_m1_full;
    logic [AW-1:0] occ_m1;
    logic         is_full;
    logic         is_empty;

    result_t      rq_reg [2];
    logic         rq_wr_reg;
    logic         rq_rd_reg;
    logic [1:0]   rq_cnt_reg;
    logic         rq_space;
    logic         rq_push;
    logic         rq_pop;
    result_t      rq_beat;

    assign occ_m1_full = occ_reg - CW'(1);
    assign occ_m1      = occ_m1_full[AW-1:0];
    assign is_full     = (occ_reg == CW'(CAPACITY));
    assign is_empty    = (occ_reg == '0);
    assign rq_space    = (rq_cnt_reg != 2'd2);
    assign empty       = (rq_cnt_reg == 2'd0);
    assign rq_pop      = pop && !empty;
    assign result      = rq_reg[rq_rd_reg];

    always_comb
    begin
        state_next       = state_reg;
        front_next       = front_reg;
        occ_next         = occ_reg;
        ptr_next         = ptr_reg;
        rem_next         = rem_reg;
        bwd_next         = bwd_reg;
        emit_status_next = emit_status_reg;
        cmd_take         = 1'b0;
        mem_we           = 1'b0;
        waddr            = front_reg;
        mem_re           = 1'b0;
        raddr            = front_reg;
        rq_push          = 1'b0;
        rq_beat          = '{status: ST_INSERTED, item: '0, last: 1'b1};

        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op) inside
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            if (rq_space)
                            begin
                                cmd_take = 1'b1;
                                rq_push  = 1'b1;
                                if (is_full)
                                begin
                                    rq_beat.status = ST_FULL;
                                end
                                else
                                begin
                                    mem_we   = 1'b1;
                                    occ_next = occ_reg + CW'(1);
                                    if (cmd.op == OP_PUSH_FRONT)
                                    begin
                                        waddr      = ring_dec(front_reg);
                                        front_next = waddr;
                                    end
                                    else
                                    begin
                                        // Occupancy is below capacity here,
                                        // so it fits the index width.
                                        waddr = ring_add(front_reg, occ_reg[AW-1:0]);
                                    end
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK, OP_LIST_FWD, OP_LIST_BWD:
                        begin
                            if (is_empty)
                            begin
                                if (rq_space)
                                begin
                                    cmd_take       = 1'b1;
                                    rq_push        = 1'b1;
                                    rq_beat.status = ST_EMPTY;
                                end
                            end
                            else
                            begin
                                cmd_take   = 1'b1;
                                mem_re     = 1'b1;
                                state_next = BK_EMIT;
                                if (cmd.op == OP_POP_FRONT || cmd.op == OP_LIST_FWD)
                                begin
                                    raddr = front_reg;
                                end
                                else
                                begin
                                    raddr = ring_add(front_reg, occ_m1);
                                end
                                ptr_next = raddr;
                                bwd_next = (cmd.op == OP_LIST_BWD);
                                if (cmd.op == OP_POP_FRONT || cmd.op == OP_POP_BACK)
                                begin
                                    emit_status_next = ST_REMOVED;
                                    rem_next         = '0;
                                    occ_next         = occ_m1_full;
                                    if (cmd.op == OP_POP_FRONT)
                                    begin
                                        front_next = ring_inc(front_reg);
                                    end
                                end
                                else
                                begin
                                    emit_status_next = ST_LISTED;
                                    rem_next         = occ_m1_full;
                                end
                            end
                        end
                        default:
                        begin
                            cmd_take = 1'b1;
                        end
                    endcase
                end
            end
            BK_EMIT:
            begin
                // The read data register only moves when the next element is
                // fetched, so it holds its value while the result queue is full.
                if (rq_space)
                begin
                    rq_push = 1'b1;
                    rq_beat = '{status: emit_status_reg, item: rdata_reg,
                                last: (rem_reg == '0)};
                    if (rem_reg != '0)
                    begin
                        mem_re   = 1'b1;
                        raddr    = bwd_reg ? ring_dec(ptr_reg) : ring_inc(ptr_reg);
                        ptr_next = raddr;
                        rem_next = rem_reg - CW'(1);
                    end
                    else
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= cmd.value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rq_push)
        begin
            rq_reg[rq_wr_reg] <= rq_beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BK_IDLE;
            front_reg       <= '0;
            occ_reg         <= '0;
            ptr_reg         <= '0;
            rem_reg         <= '0;
            bwd_reg         <= 1'b0;
            emit_status_reg <= ST_REMOVED;
            rq_wr_reg       <= 1'b0;
            rq_rd_reg       <= 1'b0;
            rq_cnt_reg      <= 2'd0;
        end
        else
        begin
            state_reg       <= state_next;
            front_reg       <= front_next;
            occ_reg         <= occ_next;
            ptr_reg         <= ptr_next;
            rem_reg         <= rem_next;
            bwd_reg         <= bwd_next;
            emit_status_reg <= emit_status_next;
            rq_wr_reg       <= rq_push ? ~rq_wr_reg : rq_wr_reg;
            rq_rd_reg       <= rq_pop ? ~rq_rd_reg : rq_rd_reg;
            rq_cnt_reg      <= rq_cnt_reg + {1'b0, rq_push} - {1'b0, rq_pop};
        end
    end

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(CAPACITY))
        else $error("occupancy exceeds capacity");

    a_rq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rq_cnt_reg != 2'd3)
        else $error("result queue count out of range");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !mem_re)
        else $error("ring written and read in the same cycle");

    a_read_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |=> (state_reg == BK_EMIT))
        else $error("ring read without an emit to follow");

    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rq_push && state_reg == BK_IDLE) |-> rq_beat.last)
        else $error("single-beat result not marked last");
`endif

endmodule : dq_back
`default_nettype wire
